/* sv/apct_pkg.sv */
// ----------------------------------------------------------------------------
// apct_pkg
// Shared types and constants for the AABB pair contact tracker.
// ----------------------------------------------------------------------------
package apct_pkg;

  localparam int unsigned ID_BITS_DEF    = 6;
  localparam int unsigned COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_ev_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_EVAL
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic clr_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } dp_sts_t;

endpackage

/* sv/apct_pair_if.sv */
// ----------------------------------------------------------------------------
// apct_pair_if
// Candidate pair request channel: ids plus centre and size of both boxes.
// ----------------------------------------------------------------------------
interface apct_pair_if
  import apct_pkg::*;
#(
  parameter int unsigned ID_BITS    = ID_BITS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic        [ID_BITS-1:0]    left_id;
  logic        [ID_BITS-1:0]    right_id;
  logic signed [COORD_BITS-1:0] left_x;
  logic signed [COORD_BITS-1:0] left_y;
  logic        [COORD_BITS-1:0] left_w;
  logic        [COORD_BITS-1:0] left_h;
  logic signed [COORD_BITS-1:0] right_x;
  logic signed [COORD_BITS-1:0] right_y;
  logic        [COORD_BITS-1:0] right_w;
  logic        [COORD_BITS-1:0] right_h;

  modport source (
    output valid, left_id, right_id, left_x, left_y, left_w, left_h,
           right_x, right_y, right_w, right_h,
    input  ready
  );

  modport sink (
    input  valid, left_id, right_id, left_x, left_y, left_w, left_h,
           right_x, right_y, right_w, right_h,
    output ready
  );
endinterface

/* sv/apct_res_if.sv */
// ----------------------------------------------------------------------------
// apct_res_if
// Contact result channel: event code and overlap flag.
// ----------------------------------------------------------------------------
interface apct_res_if
  import apct_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] contact_event;
  logic       overlapping;

  modport source (
    output valid, contact_event, overlapping,
    input  ready
  );

  modport sink (
    input  valid, contact_event, overlapping,
    output ready
  );
endinterface

/* sv/aabb_pair_contact_tracker_top.sv */
// ----------------------------------------------------------------------------
// aabb_pair_contact_tracker_top
// AABB pair overlap test with enter/stay/exit tracking per ordered id pair.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        left/right id, x, y, w, h
//  out_ch   out  valid/ready        contact_event, overlapping
//
//  Each request passes capture, |d|/span compute with table read,
//  then compare and table write; the table read is registered.
//  After reset the table of 2^(2*ID_BITS) entries (4096 at default) is
//  swept to zero with in_ch.ready low. A held result stalls the commit
//  step only; the result register frees when out_ch.ready is seen.
// ----------------------------------------------------------------------------
module aabb_pair_contact_tracker_top
  import apct_pkg::*;
#(
  parameter int unsigned ID_BITS    = ID_BITS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  apct_pair_if.sink  in_ch,
  apct_res_if.source out_ch
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  apct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  apct_dp #(
    .ID_BITS    (ID_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );
endmodule

/* sv/apct_ram.sv */
// ----------------------------------------------------------------------------
// apct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module apct_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/apct_dp.sv */
// ----------------------------------------------------------------------------
// apct_dp
// Datapath: input capture, overlap arithmetic, touching table, result register.
// ----------------------------------------------------------------------------
module apct_dp
  import apct_pkg::*;
#(
  parameter int unsigned ID_BITS    = ID_BITS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  apct_pair_if.sink  in_ch,
  apct_res_if.source out_ch,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts
);
  localparam int unsigned IDX_BITS  = 2 * ID_BITS;
  localparam int unsigned TBL_DEPTH = 1 << IDX_BITS;
  localparam int unsigned W         = COORD_BITS;

  logic        [ID_BITS-1:0]  lid_r, rid_r;
  logic signed [W-1:0]        lx_r, ly_r, rx_r, ry_r;
  logic        [W-1:0]        lw_r, lh_r, rw_r, rh_r;
  logic        [W:0]          absx_r, absy_r, spanx_r, spany_r;
  logic        [W:0]          absx_nxt, absy_nxt;
  logic signed [W:0]          dx, dy;
  logic        [IDX_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  contact_ev_t                out_ev_r, ev;
  logic                       out_hit_r, hit, was, same_id;
  logic                       ram_we, ram_wdata;
  logic        [IDX_BITS-1:0] ram_waddr, pair_idx;

  // capture request
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      lid_r <= in_ch.left_id;
      rid_r <= in_ch.right_id;
      lx_r  <= in_ch.left_x;
      ly_r  <= in_ch.left_y;
      lw_r  <= in_ch.left_w;
      lh_r  <= in_ch.left_h;
      rx_r  <= in_ch.right_x;
      ry_r  <= in_ch.right_y;
      rw_r  <= in_ch.right_w;
      rh_r  <= in_ch.right_h;
    end
  end

  // |dx|, |dy| and spans, registered every cycle
  always_comb begin
    dx       = $signed({lx_r[W-1], lx_r}) - $signed({rx_r[W-1], rx_r});
    dy       = $signed({ly_r[W-1], ly_r}) - $signed({ry_r[W-1], ry_r});
    absx_nxt = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
    absy_nxt = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
  end

  always_ff @(posedge clk) begin
    absx_r  <= absx_nxt;
    absy_r  <= absy_nxt;
    spanx_r <= {1'b0, lw_r} + {1'b0, rw_r};
    spany_r <= {1'b0, lh_r} + {1'b0, rh_r};
  end

  // table read address follows the captured pair
  assign pair_idx = {lid_r, rid_r};
  assign same_id  = (lid_r == rid_r);

  always_comb begin
    hit = ({absx_r, 1'b0} < {1'b0, spanx_r}) && ({absy_r, 1'b0} < {1'b0, spany_r});
    if (same_id) begin
      ev = EV_NONE;
    end else if (hit) begin
      ev = was ? EV_STAY : EV_ENTER;
    end else begin
      ev = was ? EV_EXIT : EV_NONE;
    end
  end

  // table write: clearing sweep or commit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pair_idx;
    ram_wdata = hit;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 1'b0;
    end else if (cmd.commit && !same_id) begin
      ram_we = 1'b1;
    end
  end

  apct_ram #(
    .WIDTH (1),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pair_idx),
    .rdata (was)
  );

  assign clr_cnt_nxt = cmd.clr_step ? clr_cnt_r + IDX_BITS'(1) : clr_cnt_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ev_r  <= ev;
      out_hit_r <= hit;
    end
  end

  assign sts.clr_last = &clr_cnt_r;
  assign sts.out_busy = out_valid_r && !out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.contact_event = out_ev_r;
  assign out_ch.overlapping   = out_hit_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.out_busy)
    else $error("result register overwritten while held");

  a_enter_overlaps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (ev == EV_ENTER || ev == EV_STAY)) |=> out_hit_r)
    else $error("enter/stay without overlap");

  a_same_id_none: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && same_id) |=> (out_ev_r == EV_NONE))
    else $error("event reported for equal ids");
endmodule

/* sv/apct_ctrl.sv */
// ----------------------------------------------------------------------------
// apct_ctrl
// Controller: table clearing sweep, then capture / compute / commit per request.
// ----------------------------------------------------------------------------
module apct_ctrl
  import apct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);
  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CALC))
    else $error("accepted request did not start compute");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (state_r == S_IDLE && !cmd.clr_step))
    else $error("commit did not return to idle");
endmodule
